>>> sv/lmsd_pkg.sv
`timescale 1ns / 1ps

package lmsd_pkg;

   // register map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_SCAN_ENABLE   = 3'd0;
   localparam logic [2:0] REG_ADDRESS_SETUP = 3'd1;
   localparam logic [2:0] REG_LATCH_HIGH    = 3'd2;
   localparam logic [2:0] REG_LATCH_LOW     = 3'd3;
   localparam logic [2:0] REG_ROW_ON        = 3'd4;

   // register reset values
   localparam logic [15:0] ADDRESS_SETUP_RESET = 16'd4;
   localparam logic [15:0] LATCH_HIGH_RESET    = 16'd2;
   localparam logic [15:0] LATCH_LOW_RESET     = 16'd2;
   localparam logic [15:0] ROW_ON_RESET        = 16'd100;

   localparam int ROW_SEL_W = 5;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_SWAP  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_START    = 3'd0,
      PH_DATA     = 3'd1,
      PH_CLOCK    = 3'd2,
      PH_BLANK    = 3'd3,
      PH_SETUP    = 3'd4,
      PH_LATCH_HI = 3'd5,
      PH_LATCH_LO = 3'd6,
      PH_ROW_ON   = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_MERGE,
      ST_CLEAR,
      ST_POST
   } state_type;

   typedef struct packed {
      logic        scan_enable;
      logic [15:0] address_setup_ticks;
      logic [15:0] latch_high_ticks;
      logic [15:0] latch_low_ticks;
      logic [15:0] row_on_ticks;
   } cfg_type;

   // panel pins: data bits 0..2 top red/green/blue, 3..5 bottom
   typedef struct packed {
      logic [ROW_SEL_W-1:0] row_select;
      logic                 output_disable;
      logic                 latch;
      logic                 shift_clock;
      logic [5:0]           data;
   } pins_type;

   localparam pins_type PINS_RESET = '{row_select: '0, output_disable: 1'b1,
                                       latch: 1'b0, shift_clock: 1'b0, data: '0};

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic merge;
      logic sweep;
      logic sweep_all;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_col;
      logic is_clear;
      logic sweep_last;
   } status_type;

endpackage

>>> sv/lmsd_req_if.sv
`timescale 1ns / 1ps

interface lmsd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] pos_x;
   logic [7:0] pos_y;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, kind, pos_x, pos_y, red, green, blue, input ready);
   modport sink (input valid, kind, pos_x, pos_y, red, green, blue, output ready);
endinterface

>>> sv/lmsd_rsp_if.sv
`timescale 1ns / 1ps

interface lmsd_rsp_if;
   logic       valid;
   logic       ready;
   logic       red_top;
   logic       green_top;
   logic       blue_top;
   logic       red_bottom;
   logic       green_bottom;
   logic       blue_bottom;
   logic       shift_clock;
   logic       latch;
   logic       output_disable;
   logic [4:0] row_select;

   modport source (output valid, red_top, green_top, blue_top, red_bottom, green_bottom,
                   blue_bottom, shift_clock, latch, output_disable, row_select,
                   input ready);
   modport sink (input valid, red_top, green_top, blue_top, red_bottom, green_bottom,
                 blue_bottom, shift_clock, latch, output_disable, row_select,
                 output ready);
endinterface

>>> sv/lmsd_csr.sv
`timescale 1ns / 1ps

module lmsd_csr
   import lmsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SCAN_ENABLE:   cfg_in.scan_enable         = pwdata[0];
            REG_ADDRESS_SETUP: cfg_in.address_setup_ticks = pwdata[15:0];
            REG_LATCH_HIGH:    cfg_in.latch_high_ticks    = pwdata[15:0];
            REG_LATCH_LOW:     cfg_in.latch_low_ticks     = pwdata[15:0];
            REG_ROW_ON:        cfg_in.row_on_ticks        = pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_enable         <= 1'b0;
         cfg_ff.address_setup_ticks <= ADDRESS_SETUP_RESET;
         cfg_ff.latch_high_ticks    <= LATCH_HIGH_RESET;
         cfg_ff.latch_low_ticks     <= LATCH_LOW_RESET;
         cfg_ff.row_on_ticks        <= ROW_ON_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_SCAN_ENABLE:   prdata = {31'd0, cfg_ff.scan_enable};
         REG_ADDRESS_SETUP: prdata = {16'd0, cfg_ff.address_setup_ticks};
         REG_LATCH_HIGH:    prdata = {16'd0, cfg_ff.latch_high_ticks};
         REG_LATCH_LOW:     prdata = {16'd0, cfg_ff.latch_low_ticks};
         REG_ROW_ON:        prdata = {16'd0, cfg_ff.row_on_ticks};
         default:           prdata = '0;
      endcase
   end

endmodule

>>> sv/lmsd_ctrl.sv
`timescale 1ns / 1ps

module lmsd_ctrl
   import lmsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep     = 1'b1;
            cmd.sweep_all = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.is_clear) begin
               state_in = ST_CLEAR;
            end else if (status.need_col) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_POST;
            end
         end
         ST_FETCH: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = ST_POST;
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // output slot occupancy
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   // a new response only comes out of the post state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_POST))
      else $error("response raised outside post state");

   // an accepted request is executed next
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_EXEC)
      else $error("accepted request not executed");

   // a finished clear always reports
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && status.sweep_last) |=> state_ff == ST_POST)
      else $error("clear sweep did not end in post");
`endif

endmodule

>>> sv/lmsd_dpath.sv
`timescale 1ns / 1ps

module lmsd_dpath
   import lmsd_pkg::*;
#(
   parameter int PANEL_WIDTH = 64,
   parameter int SCAN_ROWS   = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  cfg_type    cfg,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_pos_x,
   input  logic [7:0] req_pos_y,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output pins_type   rsp_pins
);

   localparam int DEPTH = PANEL_WIDTH * 2 * SCAN_ROWS;
   localparam int HALF  = PANEL_WIDTH * SCAN_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int COL_W = $clog2(PANEL_WIDTH);

   // pixel memories, one per buffer
   logic [2:0] mem0 [DEPTH];
   logic [2:0] mem1 [DEPTH];

   // captured request
   kind_type   kind_ff;
   logic [7:0] pos_x_ff;
   logic [7:0] pos_y_ff;
   logic [2:0] bits_ff;

   // scan state
   logic                 front_ff, front_in;
   logic                 swap_ff, swap_in;
   logic [ROW_SEL_W-1:0] row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   phase_type            phase_ff, phase_in;
   logic [15:0]          wait_ff, wait_in;
   pins_type             pins_ff, pins_in;
   pins_type             rsp_pins_ff;
   logic [AW-1:0]        sweep_ff, sweep_in;

   logic          in_panel;
   logic          write_hit;
   logic          need_col;
   logic          sweep_last;
   logic [AW-1:0] pix_addr;
   logic [AW-1:0] top_addr;
   logic [AW-1:0] bot_addr;
   logic [AW-1:0] wr_addr;
   logic [2:0]    wr_data;
   logic          we0, we1;
   logic [2:0]    rd0_top_ff, rd0_bot_ff, rd1_top_ff, rd1_bot_ff;
   logic [2:0]    top_bits, bot_bits;

   assign rsp_pins = rsp_pins_ff;

   // status to the controller
   assign status = '{need_col: need_col, is_clear: (kind_ff == KIND_CLEAR),
                     sweep_last: sweep_last};

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff  <= kind_type'(req_kind);
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         bits_ff  <= {req_blue != 8'd0, req_green != 8'd0, req_red != 8'd0};
      end
   end

   // pixel write address and panel bounds
   assign in_panel  = ({1'b0, pos_x_ff} < 9'(PANEL_WIDTH)) &&
                      ({1'b0, pos_y_ff} < 9'(2 * SCAN_ROWS));
   assign write_hit = cmd.exec && (kind_ff == KIND_WRITE) && in_panel;
   assign pix_addr  = AW'(pos_y_ff) * AW'(PANEL_WIDTH) + AW'(pos_x_ff);

   // scan read addresses for the current column of the row pair
   assign top_addr = AW'(row_ff) * AW'(PANEL_WIDTH) + AW'(col_ff);
   assign bot_addr = top_addr + AW'(HALF);

   // write port: sweeps clear, writes go to the back buffer
   assign wr_addr = cmd.sweep ? sweep_ff : pix_addr;
   assign wr_data = cmd.sweep ? 3'b000 : bits_ff;
   assign we0 = (cmd.sweep && (cmd.sweep_all || front_ff)) || (write_hit && front_ff);
   assign we1 = (cmd.sweep && (cmd.sweep_all || !front_ff)) || (write_hit && !front_ff);

   always_ff @(posedge clock) begin
      if (we0) begin
         mem0[wr_addr] <= wr_data;
      end
      rd0_top_ff <= mem0[top_addr];
      rd0_bot_ff <= mem0[bot_addr];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         mem1[wr_addr] <= wr_data;
      end
      rd1_top_ff <= mem1[top_addr];
      rd1_bot_ff <= mem1[bot_addr];
   end

   assign top_bits = front_ff ? rd1_top_ff : rd0_top_ff;
   assign bot_bits = front_ff ? rd1_bot_ff : rd0_bot_ff;

   // sweep address counter
   assign sweep_last = (sweep_ff == AW'(DEPTH - 1));
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep) begin
         sweep_in = sweep_last ? '0 : sweep_ff + AW'(1);
      end
   end

   // does this tick load a new column
   always_comb begin
      need_col = 1'b0;
      if (kind_ff == KIND_TICK && cfg.scan_enable) begin
         case (phase_ff)
            PH_START:  need_col = 1'b1;
            PH_DATA:   need_col = 1'b1;
            PH_ROW_ON: need_col = (wait_ff == 16'd0);
            default:   need_col = 1'b0;
         endcase
      end
   end

   // scan sequencing
   always_comb begin
      front_in = front_ff;
      swap_in  = swap_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      phase_in = phase_ff;
      wait_in  = wait_ff;
      pins_in  = pins_ff;
      if (cmd.exec && kind_ff == KIND_SWAP) begin
         swap_in = 1'b1;
      end
      if (cmd.exec && kind_ff == KIND_TICK) begin
         if (!cfg.scan_enable) begin
            pins_in  = PINS_RESET;
            phase_in = PH_START;
            row_in   = '0;
            col_in   = '0;
            wait_in  = '0;
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (swap_ff) begin
                     front_in = !front_ff;
                     swap_in  = 1'b0;
                  end
                  row_in = '0;
                  col_in = '0;
               end
               PH_CLOCK: begin
                  pins_in.shift_clock = 1'b1;
                  if (col_ff == COL_W'(PANEL_WIDTH - 1)) begin
                     phase_in = PH_BLANK;
                  end else begin
                     col_in   = col_ff + COL_W'(1);
                     phase_in = PH_DATA;
                  end
               end
               PH_BLANK: begin
                  pins_in.shift_clock    = 1'b0;
                  pins_in.output_disable = 1'b1;
                  pins_in.row_select     = row_ff;
                  wait_in                = cfg.address_setup_ticks;
                  phase_in               = PH_SETUP;
               end
               PH_SETUP: begin
                  if (wait_ff != 16'd0) begin
                     wait_in = wait_ff - 16'd1;
                  end else begin
                     pins_in.latch = 1'b1;
                     wait_in       = cfg.latch_high_ticks;
                     phase_in      = PH_LATCH_HI;
                  end
               end
               PH_LATCH_HI: begin
                  if (wait_ff != 16'd0) begin
                     wait_in = wait_ff - 16'd1;
                  end else begin
                     pins_in.latch = 1'b0;
                     wait_in       = cfg.latch_low_ticks;
                     phase_in      = PH_LATCH_LO;
                  end
               end
               PH_LATCH_LO: begin
                  if (wait_ff != 16'd0) begin
                     wait_in = wait_ff - 16'd1;
                  end else begin
                     pins_in.output_disable = 1'b0;
                     wait_in                = cfg.row_on_ticks;
                     phase_in               = PH_ROW_ON;
                  end
               end
               PH_ROW_ON: begin
                  if (wait_ff != 16'd0) begin
                     wait_in = wait_ff - 16'd1;
                  end else begin
                     if (row_ff == ROW_SEL_W'(SCAN_ROWS - 1)) begin
                        if (swap_ff) begin
                           front_in = !front_ff;
                           swap_in  = 1'b0;
                        end
                        row_in = '0;
                     end else begin
                        row_in = row_ff + ROW_SEL_W'(1);
                     end
                     col_in = '0;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
            // column load: clock and latch low, data follows after the read
            if (need_col) begin
               pins_in.shift_clock = 1'b0;
               pins_in.latch       = 1'b0;
               phase_in            = PH_CLOCK;
            end
         end
      end
      if (cmd.merge) begin
         pins_in.data = {bot_bits, top_bits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= 1'b0;
         swap_ff  <= 1'b0;
         row_ff   <= '0;
         col_ff   <= '0;
         phase_ff <= PH_START;
         wait_ff  <= '0;
         pins_ff  <= PINS_RESET;
         sweep_ff <= '0;
      end else begin
         front_ff <= front_in;
         swap_ff  <= swap_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         pins_ff  <= pins_in;
         sweep_ff <= sweep_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_pins_ff <= pins_ff;
      end
   end

`ifndef SYNTH
   // panel stays blank while latch is high
   assert property (@(posedge clock) disable iff (reset)
      pins_ff.latch |-> pins_ff.output_disable)
      else $error("latch high with output enabled");

   // latch only rises out of the address setup wait
   assert property (@(posedge clock) disable iff (reset)
      $rose(pins_ff.latch) |-> $past(phase_ff == PH_SETUP))
      else $error("latch rose outside address setup");

   // column data merges only into a column that waits for its clock
   assert property (@(posedge clock) disable iff (reset)
      cmd.merge |-> (phase_ff == PH_CLOCK && !pins_ff.shift_clock))
      else $error("column data merged in wrong phase");
`endif

endmodule

>>> sv/led_matrix_scan_driver.sv
// a tick that loads a column goes through exec, fetch and merge around the registered
// pixel read, then post; other ticks, pixel writes and swaps go through exec and post;
// a clear sweeps the back buffer between exec and post; a new request is taken only in
// idle, after post, which waits while the response slot is full and not yet taken
// reset: a clearing pass writes all 2*PANEL_WIDTH*SCAN_ROWS entries (4096 at defaults)
// of both buffers, during which no request is accepted; registers take writes at all times
`timescale 1ns / 1ps

module led_matrix_scan_driver
   import lmsd_pkg::*;
#(
   parameter int PANEL_WIDTH = 64,
   parameter int SCAN_ROWS   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   lmsd_req_if.sink              req_bus,
   lmsd_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   pins_type   rsp_pins;
   logic       req_ready;
   logic       rsp_valid;

   // configuration registers
   lmsd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer
   lmsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // pixel buffers and scan state
   lmsd_dpath #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .SCAN_ROWS   (SCAN_ROWS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .cfg       (cfg),
      .req_kind  (req_bus.kind),
      .req_pos_x (req_bus.pos_x),
      .req_pos_y (req_bus.pos_y),
      .req_red   (req_bus.red),
      .req_green (req_bus.green),
      .req_blue  (req_bus.blue),
      .rsp_pins  (rsp_pins)
   );

   // channel wiring
   assign req_bus.ready          = req_ready;
   assign rsp_bus.valid          = rsp_valid;
   assign rsp_bus.red_top        = rsp_pins.data[0];
   assign rsp_bus.green_top      = rsp_pins.data[1];
   assign rsp_bus.blue_top       = rsp_pins.data[2];
   assign rsp_bus.red_bottom     = rsp_pins.data[3];
   assign rsp_bus.green_bottom   = rsp_pins.data[4];
   assign rsp_bus.blue_bottom    = rsp_pins.data[5];
   assign rsp_bus.shift_clock    = rsp_pins.shift_clock;
   assign rsp_bus.latch          = rsp_pins.latch;
   assign rsp_bus.output_disable = rsp_pins.output_disable;
   assign rsp_bus.row_select     = rsp_pins.row_select;

endmodule
